/* rtl/ssba_pkg.sv */
// Shared types and constants for the swap slot bitmap allocator.
// No dependencies; imported by every module of the block except ssba_ram.
`default_nettype none

package ssba_pkg;

   // Free map is held as rows of this many slot bits
   localparam int unsigned ROW_BITS = 32;
   localparam int unsigned BIT_W    = 5;

   localparam int unsigned CMD_W      = 2;
   localparam int unsigned INDEX_W    = 10;
   localparam int unsigned SECTOR_W   = 13;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned COUNT_W    = 11;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SWAP_IN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNUSED = 2'd3;

   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

   typedef enum logic [2:0] {
      RES_SECTOR,
      RES_FULL,
      RES_RANGE,
      RES_UNUSED,
      RES_FREED
   } res_kind_type;

   // controller -> datapath
   typedef struct packed {
      logic         clr_write;
      logic         accept;
      logic         next_row;
      logic         alloc_take;
      logic         idx_release;
      logic         load;
      res_kind_type kind;
   } ssba_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_done;
      logic op_alloc;
      logic op_idx;
      logic op_swapin;
      logic idx_bad;
      logic found;
      logic row_end;
      logic bit_free;
      logic k_last;
      logic out_free;
   } ssba_stat_type;

endpackage

`default_nettype wire

/* rtl/ssba_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module ssba_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/ssba_dpath.sv */
// Datapath: slot count register, free map RAM, row scan, slot and sector
// counters and the result register. Depends on ssba_pkg and ssba_ram.
`default_nettype none

module ssba_dpath #(
   parameter int unsigned SLOTS            = 1024,
   parameter int unsigned SECTORS_PER_SLOT = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [ssba_pkg::COUNT_W-1:0]      csr_write_data,
   input  wire logic [ssba_pkg::CMD_W-1:0]        req_command,
   input  wire logic [ssba_pkg::INDEX_W-1:0]      req_slot_index,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic      [ssba_pkg::INDEX_W-1:0]      rsp_slot,
   output logic      [ssba_pkg::SECTOR_W-1:0]     rsp_sector_address,
   output logic      [ssba_pkg::STATUS_W-1:0]     rsp_status,
   output logic                                   rsp_last,
   input  wire ssba_pkg::ssba_cmd_type            cmd,
   output ssba_pkg::ssba_stat_type                stat
);

   import ssba_pkg::*;

   localparam int unsigned ROWS   = (SLOTS + ROW_BITS - 1) / ROW_BITS;
   localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned IW     = ROW_W + BIT_W;
   localparam int unsigned EFF_W  = $clog2(SLOTS + 1);
   localparam int unsigned CW0    = (EFF_W > COUNT_W) ? EFF_W : COUNT_W;
   localparam int unsigned CW     = ((CW0 > IW) ? CW0 : IW) + 1;
   localparam int unsigned XW     = (IW > INDEX_W) ? IW : INDEX_W;
   localparam int unsigned K_W    = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
   localparam int unsigned PW0    = IW + K_W + 1;
   localparam int unsigned SUM_W  = (PW0 > SECTOR_W) ? PW0 : SECTOR_W;

   logic [COUNT_W-1:0]  slot_count_ff;
   logic [CMD_W-1:0]    op_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [IW-1:0]       slot_ff;
   logic [K_W-1:0]      k_ff;

   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  rsp_slot_ff;
   logic [SECTOR_W-1:0] rsp_sector_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;

   logic [ROW_BITS-1:0] rd_data;
   logic [ROW_BITS-1:0] wr_data_in;
   logic                wr_en_in;

   logic [CW-1:0]       count_ext;
   logic [CW-1:0]       eff_count;
   logic [CW-1:0]       row_base;
   logic [CW-1:0]       rem;
   logic [ROW_BITS-1:0] limit_mask;
   logic [ROW_BITS-1:0] cand;
   logic [ROW_BITS-1:0] low;
   logic [BIT_W-1:0]    low_pos;
   logic [XW-1:0]       req_x;
   logic [XW-1:0]       slot_x;
   logic [SUM_W-1:0]    sector_sum;
   logic                k_last;
   logic                out_free;

   // Effective count is min(slot_count, SLOTS)
   assign count_ext = CW'(slot_count_ff);
   assign eff_count = (count_ext < CW'(SLOTS)) ? count_ext : CW'(SLOTS);

   // Slots of the current row that lie below the effective count
   assign row_base   = CW'({row_ff, BIT_W'(0)});
   assign rem        = eff_count - row_base;
   assign limit_mask = (rem >= CW'(ROW_BITS)) ? '1
                     : ((ROW_BITS'(1) << rem[BIT_W-1:0]) - ROW_BITS'(1));
   assign cand       = rd_data & limit_mask;
   assign low        = cand & (~cand + ROW_BITS'(1));

   always_comb begin
      low_pos = '0;
      for (int i = 0; i < ROW_BITS; i++) begin
         if (low[i]) begin
            low_pos = BIT_W'(i);
         end
      end
   end

   assign req_x  = XW'(req_slot_index);
   assign slot_x = XW'(slot_ff);

   assign sector_sum = SUM_W'(slot_ff) * SUM_W'(SECTORS_PER_SLOT) + SUM_W'(k_ff);
   assign k_last     = (k_ff == K_W'(SECTORS_PER_SLOT - 1));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      wr_en_in   = cmd.clr_write || cmd.alloc_take || cmd.idx_release;
      wr_data_in = rd_data;
      if (cmd.clr_write) begin
         wr_data_in = '1;
      end else if (cmd.alloc_take) begin
         wr_data_in = rd_data & ~low;
      end else if (cmd.idx_release) begin
         wr_data_in = rd_data | (ROW_BITS'(1) << slot_ff[BIT_W-1:0]);
      end
   end

   ssba_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_free_map (
      .clock   (clock),
      .wr_en   (wr_en_in),
      .wr_addr (row_ff),
      .wr_data (wr_data_in),
      .rd_addr (row_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
         row_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            slot_count_ff <= csr_write_data;
         end
         if (cmd.accept) begin
            row_ff <= (req_command == CMD_ALLOC) ? '0 : req_x[IW-1:BIT_W];
         end else if (cmd.clr_write || cmd.next_row) begin
            row_ff <= row_ff + ROW_W'(1);
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_command;
         idx_ff  <= req_slot_index;
         slot_ff <= req_x[IW-1:0];
         k_ff    <= '0;
      end else begin
         if (cmd.alloc_take) begin
            slot_ff <= {row_ff, low_pos};
         end
         if (cmd.load && cmd.kind == RES_SECTOR) begin
            k_ff <= k_ff + K_W'(1);
         end
      end
      if (cmd.load) begin
         case (cmd.kind)
            RES_SECTOR: begin
               rsp_slot_ff   <= slot_x[INDEX_W-1:0];
               rsp_sector_ff <= sector_sum[SECTOR_W-1:0];
               rsp_status_ff <= STATUS_OK;
               rsp_last_ff   <= k_last;
            end
            RES_FULL: begin
               rsp_slot_ff   <= '0;
               rsp_sector_ff <= '0;
               rsp_status_ff <= STATUS_FULL;
               rsp_last_ff   <= 1'b1;
            end
            RES_RANGE: begin
               rsp_slot_ff   <= idx_ff;
               rsp_sector_ff <= '0;
               rsp_status_ff <= STATUS_RANGE;
               rsp_last_ff   <= 1'b1;
            end
            RES_UNUSED: begin
               rsp_slot_ff   <= idx_ff;
               rsp_sector_ff <= '0;
               rsp_status_ff <= STATUS_UNUSED;
               rsp_last_ff   <= 1'b1;
            end
            default: begin
               rsp_slot_ff   <= idx_ff;
               rsp_sector_ff <= '0;
               rsp_status_ff <= STATUS_OK;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      stat.clr_done  = (row_ff == ROW_W'(ROWS - 1));
      stat.op_alloc  = (op_ff == CMD_ALLOC);
      stat.op_idx    = (op_ff == CMD_SWAP_IN) || (op_ff == CMD_FREE);
      stat.op_swapin = (op_ff == CMD_SWAP_IN);
      stat.idx_bad   = (CW'(idx_ff) >= eff_count);
      stat.found     = |cand;
      stat.row_end   = (rem <= CW'(ROW_BITS));
      stat.bit_free  = rd_data[slot_ff[BIT_W-1:0]];
      stat.k_last    = k_last;
      stat.out_free  = out_free;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_sector_address = rsp_sector_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef SYNTH
   // A held result must never be overwritten
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> out_free)
      else $error("result loaded while previous one still pending");

   a_take_found: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_take |-> stat.found)
      else $error("slot taken from a row with no free candidate");

   // Error statuses are always single-transfer results
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> rsp_last_ff)
      else $error("error result without last");
`endif

endmodule

`default_nettype wire

/* rtl/ssba_ctrl.sv */
// Controller state machine: clearing pass, command decode, row scan and
// result sequencing. Depends on ssba_pkg.
`default_nettype none

module ssba_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ssba_pkg::ssba_stat_type stat,
   output ssba_pkg::ssba_cmd_type      cmd
);

   import ssba_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_ALLOC_CHK,
      ST_INDEX_CHK,
      ST_EMIT,
      ST_SINGLE
   } state_type;

   state_type    state_ff, state_in;
   res_kind_type kind_ff, kind_in;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '{default: '0, kind: RES_SECTOR};
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_START;
            end
         end
         // row read is in flight here
         ST_START: begin
            if (stat.op_alloc) begin
               state_in = ST_ALLOC_CHK;
            end else if (stat.op_idx) begin
               if (stat.idx_bad) begin
                  kind_in  = RES_RANGE;
                  state_in = ST_SINGLE;
               end else begin
                  state_in = ST_INDEX_CHK;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ALLOC_CHK: begin
            if (stat.found) begin
               cmd.alloc_take = 1'b1;
               state_in       = ST_EMIT;
            end else if (stat.row_end) begin
               kind_in  = RES_FULL;
               state_in = ST_SINGLE;
            end else begin
               cmd.next_row = 1'b1;
               state_in     = ST_START;
            end
         end
         ST_INDEX_CHK: begin
            if (stat.bit_free) begin
               kind_in  = RES_UNUSED;
               state_in = ST_SINGLE;
            end else begin
               cmd.idx_release = 1'b1;
               if (stat.op_swapin) begin
                  state_in = ST_EMIT;
               end else begin
                  kind_in  = RES_FREED;
                  state_in = ST_SINGLE;
               end
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = RES_SECTOR;
               if (stat.k_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SINGLE: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = kind_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff  <= RES_FULL;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

`ifndef SYNTH
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == ST_START))
      else $error("accepted command did not enter decode");

   // clearing pass runs once, straight after reset
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
      else $error("clearing pass re-entered");
`endif

endmodule

`default_nettype wire

/* rtl/swap_slot_bitmap_allocator.sv */
// Top level of the swap slot bitmap allocator: controller plus datapath.
// Depends on ssba_pkg, ssba_ctrl, ssba_dpath (and ssba_ram below it).
//  - req channel (valid/ready): command and slot index. Allocate takes the
//    lowest free slot below min(slot_count, SLOTS); swap in reads and frees
//    a used slot; free just frees it. Code 3 is taken and dropped silently.
//  - rsp channel (valid/ready): SECTORS_PER_SLOT transfers for a successful
//    allocate or swap in (last on the final one), otherwise one transfer.
//  - csr_write_enable/csr_write_data load slot_count; write only when idle.
//  - Timing: one command at a time. The idle cycle takes it; an allocate
//    then spends a START state (RAM read) and an ALLOC_CHK state (check)
//    per 32-slot row scanned, swap in and free a START and an INDEX_CHK
//    state on the read and slot check; sectors leave one per cycle while
//    the receiver is ready.
//  - After reset the free map RAM is swept to all-free, one row per cycle,
//    over ceil(SLOTS/32) rows (32 at defaults), with req_ready low.
//  - A stalled receiver holds the result register and the block waits;
//    nothing is dropped.
`default_nettype none

module swap_slot_bitmap_allocator #(
   parameter int unsigned SLOTS            = 1024,
   parameter int unsigned SECTORS_PER_SLOT = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [ssba_pkg::COUNT_W-1:0]  csr_write_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ssba_pkg::CMD_W-1:0]    req_command,
   input  wire logic [ssba_pkg::INDEX_W-1:0]  req_slot_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [ssba_pkg::INDEX_W-1:0]  rsp_slot,
   output logic      [ssba_pkg::SECTOR_W-1:0] rsp_sector_address,
   output logic      [ssba_pkg::STATUS_W-1:0] rsp_status,
   output logic                               rsp_last
);

   import ssba_pkg::*;

   ssba_cmd_type  cmd;
   ssba_stat_type stat;

   ssba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssba_dpath #(
      .SLOTS            (SLOTS),
      .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_command        (req_command),
      .req_slot_index     (req_slot_index),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_slot           (rsp_slot),
      .rsp_sector_address (rsp_sector_address),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for swap_slot_bitmap_allocator: directed and random
// swap commands, with a bitmap predictor and an in-order response scoreboard.
// Depends on ssba_pkg and the allocator RTL only.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ssba_pkg::*;

   localparam int unsigned NUM_SLOTS     = 1024;
   localparam int unsigned SECTORS       = 8;
   localparam int unsigned SETTLE_CYCLES = 100;   // longest allocate scan plus margin
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned QUIET_LIMIT   = 2000;

   // Code 3 is accepted and dropped by the block
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [CMD_W-1:0]   command;
      logic [INDEX_W-1:0] slot_index;
      bit                 drain;    // hold this command back until all reports are in
   } swap_command_type;

   typedef struct {
      logic [INDEX_W-1:0]  slot;
      logic [SECTOR_W-1:0] sector_address;
      logic [STATUS_W-1:0] status;
      logic                last;
   } slot_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command = CMD_ALLOC;
   logic [INDEX_W-1:0]  req_slot_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [INDEX_W-1:0]  rsp_slot;
   logic [SECTOR_W-1:0] rsp_sector_address;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;

   // Predictor state
   logic [NUM_SLOTS-1:0] slot_free = '1;
   logic [COUNT_W-1:0]   slot_limit = SLOT_COUNT_RESET;

   swap_command_type queued_commands[$];
   slot_report_type  due_reports[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned holds_asked = 0;
   int unsigned holds_granted = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;
   int unsigned commands_taken = 0;
   int unsigned reports_seen = 0;
   int unsigned status_tally[4] = '{0, 0, 0, 0};

   swap_slot_bitmap_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_slot_index     (req_slot_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_slot           (rsp_slot),
      .rsp_sector_address (rsp_sector_address),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic void push_report(logic [INDEX_W-1:0] slot, logic [SECTOR_W-1:0] sector,
                                       logic [STATUS_W-1:0] status, logic last);
      slot_report_type r;
      r.slot = slot;
      r.sector_address = sector;
      r.status = status;
      r.last = last;
      due_reports.push_back(r);
   endfunction

   function automatic void push_sectors(logic [INDEX_W-1:0] slot);
      for (int k = 0; k < SECTORS; k++)
         push_report(slot, SECTOR_W'(slot * SECTORS + k), STATUS_OK, k == SECTORS - 1);
   endfunction

   // First-fit allocate, swap in and free against the shadow free map
   function automatic void apply_swap_command(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx);
      int unsigned usable;
      int unsigned s;
      usable = (slot_limit < NUM_SLOTS) ? slot_limit : NUM_SLOTS;
      case (cmd)
         CMD_ALLOC: begin
            s = 0;
            while (s < usable && !slot_free[s])
               s++;
            if (s < usable) begin
               slot_free[s] = 1'b0;
               push_sectors(INDEX_W'(s));
            end else begin
               push_report('0, '0, STATUS_FULL, 1'b1);
            end
         end
         CMD_SWAP_IN, CMD_FREE: begin
            if (idx >= usable) begin
               push_report(idx, '0, STATUS_RANGE, 1'b1);
            end else if (slot_free[idx]) begin
               push_report(idx, '0, STATUS_UNUSED, 1'b1);
            end else begin
               slot_free[idx] = 1'b1;
               if (cmd == CMD_SWAP_IN)
                  push_sectors(idx);
               else
                  push_report(idx, '0, STATUS_OK, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   // Four-state compare, so an unknown field counts as a mismatch
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Mostly in-range indexes near the bottom of the map, where first fit puts used slots
   function automatic swap_command_type random_command(int unsigned usable, bit drain);
      swap_command_type c;
      int unsigned roll;
      int unsigned span;
      roll = $urandom_range(0, 99);
      span = (usable < 48) ? usable : 48;
      c.command = CMD_ALLOC;
      c.slot_index = INDEX_W'($urandom_range(0, NUM_SLOTS - 1));
      c.drain = drain;
      if (roll >= 40 && roll < 88 && span != 0) begin
         c.command = (roll < 65) ? CMD_SWAP_IN : CMD_FREE;
         c.slot_index = INDEX_W'($urandom_range(0, span - 1));
      end else if (roll >= 88 && roll < 95) begin
         c.command = $urandom_range(0, 1) ? CMD_SWAP_IN : CMD_FREE;
         if (usable < NUM_SLOTS)
            c.slot_index = INDEX_W'($urandom_range(usable, NUM_SLOTS - 1));
      end else if (roll >= 95) begin
         c.command = CMD_UNUSED;
      end
      return c;
   endfunction

   task automatic queue_command(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx);
      swap_command_type c;
      c.command = cmd;
      c.slot_index = idx;
      c.drain = 1'b0;
      queued_commands.push_back(c);
   endtask

   // Sampled on the falling edge, clear of the driver and monitor updates
   task automatic wait_until_idle();
      do
         @(negedge clock);
      while (queued_commands.size() != 0 || req_valid || due_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_slot_count(logic [COUNT_W-1:0] value);
      wait_until_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      slot_limit = value;
   endtask

   task automatic random_phase(int unsigned count, int unsigned n, bit long_hold);
      set_slot_count(COUNT_W'(count));
      for (int i = 0; i < n; i++)
         queued_commands.push_back(random_command(count,
                                   (i == n / 2) || ($urandom_range(0, 39) == 0)));
      if (long_hold)
         holds_asked++;
   endtask

   // Request driver
   always @(posedge clock) begin : drive_commands
      swap_command_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_swap_command(req_command, req_slot_index);
            commands_taken++;
         end
         if (!req_valid || req_ready) begin
            if (queued_commands.size() != 0
                && !(queued_commands[0].drain && due_reports.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct) begin
               head = queued_commands.pop_front();
               req_valid <= 1'b1;
               req_command <= head.command;
               req_slot_index <= head.slot_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and back-pressure
   always @(posedge clock) begin : check_reports
      slot_report_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            reports_seen++;
            if (due_reports.size() == 0) begin
               $display({"%0t: unexpected transfer, expected none, ",
                         "actual slot %0d sector %0d status %0d last %0d"},
                        $time, rsp_slot, rsp_sector_address, rsp_status, rsp_last);
               mismatches++;
            end else begin
               due = due_reports.pop_front();
               check_field("slot", 32'(due.slot), 32'(rsp_slot));
               check_field("sector_address", 32'(due.sector_address),
                           32'(rsp_sector_address));
               check_field("status", 32'(due.status), 32'(rsp_status));
               check_field("last", 32'(due.last), 32'(rsp_last));
               status_tally[due.status]++;
            end
         end
         if (holds_granted < holds_asked) begin
            holds_granted++;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 33;
      recv_stall_pct = 53;

      // Four slots: fill, overflow, swap in, double release, range errors, dropped code
      set_slot_count(11'd4);
      repeat (4) queue_command(CMD_ALLOC, 10'd0);
      queue_command(CMD_ALLOC, 10'h3FF);
      queue_command(CMD_SWAP_IN, 10'd2);
      queue_command(CMD_SWAP_IN, 10'd2);
      queue_command(CMD_FREE, 10'd3);
      queue_command(CMD_FREE, 10'd3);
      queue_command(CMD_FREE, 10'd4);
      queue_command(CMD_SWAP_IN, 10'h3FF);
      queue_command(CMD_UNUSED, 10'h155);
      queue_command(CMD_ALLOC, 10'h2AA);
      queue_command(CMD_FREE, 10'd0);

      // No slots at all
      set_slot_count(11'd0);
      queue_command(CMD_ALLOC, 10'd0);
      queue_command(CMD_FREE, 10'd0);
      queue_command(CMD_SWAP_IN, 10'd1);

      // Count beyond the map clamps to the full map
      set_slot_count(11'h7FF);
      queue_command(CMD_ALLOC, 10'd0);
      queue_command(CMD_SWAP_IN, 10'h3FF);
      queue_command(CMD_FREE, 10'h3FF);
      queue_command(CMD_UNUSED, 10'h2AA);
      queue_command(CMD_SWAP_IN, 10'd1);

      random_phase(4, 48, 1'b0);
      random_phase(1, 40, 1'b0);
      random_phase(16, 48, 1'b1);

      wait_until_idle();
      send_idle_pct = 53;
      recv_stall_pct = 33;
      random_phase(1024, 48, 1'b0);
      random_phase(37, 48, 1'b1);
      random_phase(9, 48, 1'b0);

      wait_until_idle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_phase(2, 40, 1'b0);
      random_phase($urandom_range(3, 64), 48, 1'b0);
      random_phase(1024, 48, 1'b1);

      wait_until_idle();
      $display("Covered %0d commands, %0d responses (ok %0d, full %0d, range %0d, %s %0d)",
               commands_taken, reports_seen, status_tally[STATUS_OK],
               status_tally[STATUS_FULL], status_tally[STATUS_RANGE], "not in use",
               status_tally[STATUS_UNUSED]);
      $display("Slot counts 0, 1, 2, 4, 9, 16, 37, 1024, 2047 and one random count, %s",
               "with varied idling and long holds");
      if (mismatches == 0 && due_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
